FILE: sv/eucjp_pkg.sv
`timescale 1ns / 1ps

package eucjp_pkg;

	// Default width of the running score.
	localparam int unsigned SCORE_BITS_DEF = 16;

	// Width of the score field on the result channel.
	localparam int unsigned OUT_BITS = 16;

	// Byte codes that the decoder looks for.
	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_TAB   = 8'h09;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_ESC   = 8'h1B;
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_HIGH  = 8'h80;
	localparam logic [7:0] BYTE_SS2   = 8'h8E;
	localparam logic [7:0] BYTE_SS3   = 8'h8F;
	localparam logic [7:0] EUC_LO     = 8'hA1;
	localparam logic [7:0] KANA_HI    = 8'hDF;
	localparam logic [7:0] EUC_HI     = 8'hFE;

	// Where the decoder stands within a multi-byte character.
	typedef enum logic [2:0] {
		PH_LEAD  = 3'd0,
		PH_TRAIL = 3'd1,
		PH_KANA  = 3'd2,
		PH_SS3_1 = 3'd3,
		PH_SS3_2 = 3'd4
	} phase_t;

	// Control state carried from one byte to the next.
	typedef struct packed {
		phase_t phase;
		logic   reject;
	} ctrl_t;

	function automatic logic is_euc(input logic [7:0] c);
		is_euc = (c >= EUC_LO) && (c <= EUC_HI);
	endfunction

	function automatic logic is_kana(input logic [7:0] c);
		is_kana = (c >= EUC_LO) && (c <= KANA_HI);
	endfunction

endpackage

FILE: sv/eucjp_content_scorer_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// input    in         in_valid/in_stall  data_byte[7:0], end_of_buffer
// result   out        out_valid/out_stall score[15:0], rejected
//
// A byte is registered on the transfer and decoded in the following cycle, which
// updates the character phase, the running score and the reject flag.
// One byte can be taken in every cycle while the input does not stall; the result
// of a buffer passes through the input register and then the result register.
// Reset empties both registers and returns the decoder to the lead-byte phase
// with a zero score. The input stalls only when the registered byte ends a
// buffer and a previous result is still held by a stalled output.
module eucjp_content_scorer_top #(
	parameter int unsigned SCORE_BITS = eucjp_pkg::SCORE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_buffer,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [eucjp_pkg::OUT_BITS-1:0] score,
	output logic                           rejected
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// Decoder state.
	eucjp_pkg::ctrl_t      ctrl_q;
	logic [SCORE_BITS-1:0] score_q;

	eucjp_pkg::ctrl_t               ctrl_nxt;
	logic [SCORE_BITS-1:0]          score_nxt;
	logic [eucjp_pkg::OUT_BITS-1:0] res_score;
	logic                           res_rejected;

	logic out_busy;
	logic advance;
	logic in_xfer;

	// The registered byte moves on unless it ends a buffer and the result
	// register cannot take the result.
	assign advance  = valid_s1 & ~(eob_s1 & out_busy);
	assign in_stall = valid_s1 & ~advance;
	assign in_xfer  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer | in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	eucjp_step #(
		.SCORE_BITS (SCORE_BITS)
	) u_step (
		.ctrl_cur     (ctrl_q),
		.score_cur    (score_q),
		.data_byte    (byte_s1),
		.ctrl_nxt     (ctrl_nxt),
		.score_nxt    (score_nxt),
		.res_score    (res_score),
		.res_rejected (res_rejected)
	);

	// At the end of a buffer the state returns to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '{phase: eucjp_pkg::PH_LEAD, reject: 1'b0};
			score_q <= '0;
		end else if (advance) begin
			if (eob_s1) begin
				ctrl_q  <= '{phase: eucjp_pkg::PH_LEAD, reject: 1'b0};
				score_q <= '0;
			end else begin
				ctrl_q  <= ctrl_nxt;
				score_q <= score_nxt;
			end
		end
	end

	eucjp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance & eob_s1),
		.load_score    (res_score),
		.load_rejected (res_rejected),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.busy          (out_busy),
		.score         (score),
		.rejected      (rejected)
	);

endmodule

FILE: sv/eucjp_step.sv
`timescale 1ns / 1ps

// Next-state logic for one byte, and the result value for the end of a buffer.
module eucjp_step #(
	parameter int unsigned SCORE_BITS = eucjp_pkg::SCORE_BITS_DEF
) (
	input  eucjp_pkg::ctrl_t                 ctrl_cur,
	input  logic [SCORE_BITS-1:0]            score_cur,
	input  logic [7:0]                       data_byte,
	output eucjp_pkg::ctrl_t                 ctrl_nxt,
	output logic [SCORE_BITS-1:0]            score_nxt,
	output logic [eucjp_pkg::OUT_BITS-1:0]   res_score,
	output logic                             res_rejected
);

	localparam int unsigned WIDE_BITS =
		(SCORE_BITS > eucjp_pkg::OUT_BITS) ? SCORE_BITS : eucjp_pkg::OUT_BITS;

	logic [SCORE_BITS-1:0] score_inc;
	logic [SCORE_BITS-1:0] score_dec;
	logic [WIDE_BITS-1:0]  score_wide;
	logic [WIDE_BITS-1:0]  out_max_wide;
	logic                  is_ctrl;

	assign score_inc = (&score_cur) ? score_cur : score_cur + 1'b1;
	assign score_dec = (score_cur == '0) ? score_cur : score_cur - 1'b1;

	assign is_ctrl = (data_byte < eucjp_pkg::BYTE_SPACE)
		&& (data_byte != eucjp_pkg::BYTE_TAB)
		&& (data_byte != eucjp_pkg::BYTE_LF)
		&& (data_byte != eucjp_pkg::BYTE_CR);

	always_comb begin
		ctrl_nxt  = ctrl_cur;
		score_nxt = score_cur;
		if (!ctrl_cur.reject) begin
			unique case (ctrl_cur.phase)
				eucjp_pkg::PH_LEAD: begin
					if (data_byte == eucjp_pkg::BYTE_NUL
						|| data_byte == eucjp_pkg::BYTE_ESC) begin
						ctrl_nxt.reject = 1'b1;
					end else if (is_ctrl) begin
						score_nxt = score_dec;
					end else if (data_byte < eucjp_pkg::BYTE_HIGH) begin
						score_nxt = score_cur;
					end else if (data_byte == eucjp_pkg::BYTE_SS2) begin
						score_nxt      = score_inc;
						ctrl_nxt.phase = eucjp_pkg::PH_KANA;
					end else if (data_byte == eucjp_pkg::BYTE_SS3) begin
						score_nxt      = score_inc;
						ctrl_nxt.phase = eucjp_pkg::PH_SS3_1;
					end else if (eucjp_pkg::is_euc(data_byte)) begin
						score_nxt      = score_inc;
						ctrl_nxt.phase = eucjp_pkg::PH_TRAIL;
					end else begin
						ctrl_nxt.reject = 1'b1;
					end
				end
				eucjp_pkg::PH_KANA: begin
					if (eucjp_pkg::is_kana(data_byte)) begin
						score_nxt      = score_inc;
						ctrl_nxt.phase = eucjp_pkg::PH_LEAD;
					end else begin
						ctrl_nxt.reject = 1'b1;
						ctrl_nxt.phase  = eucjp_pkg::PH_LEAD;
					end
				end
				eucjp_pkg::PH_SS3_1: begin
					if (eucjp_pkg::is_euc(data_byte)) begin
						score_nxt      = score_inc;
						ctrl_nxt.phase = eucjp_pkg::PH_SS3_2;
					end else begin
						ctrl_nxt.reject = 1'b1;
						ctrl_nxt.phase  = eucjp_pkg::PH_LEAD;
					end
				end
				default: begin
					if (eucjp_pkg::is_euc(data_byte)) begin
						score_nxt = score_inc;
					end else begin
						ctrl_nxt.reject = 1'b1;
					end
					ctrl_nxt.phase = eucjp_pkg::PH_LEAD;
				end
			endcase
		end
	end

	// The result field saturates again when the running score is wider.
	assign score_wide   = WIDE_BITS'(score_nxt);
	assign out_max_wide = WIDE_BITS'({eucjp_pkg::OUT_BITS{1'b1}});

	always_comb begin
		res_rejected = ctrl_nxt.reject;
		if (ctrl_nxt.reject) begin
			res_score = '0;
		end else if (score_wide > out_max_wide) begin
			res_score = {eucjp_pkg::OUT_BITS{1'b1}};
		end else begin
			res_score = score_wide[eucjp_pkg::OUT_BITS-1:0];
		end
	end

endmodule

FILE: sv/eucjp_out_reg.sv
`timescale 1ns / 1ps

// Result register: holds one result until the downstream side takes it.
module eucjp_out_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic [eucjp_pkg::OUT_BITS-1:0] load_score,
	input  logic                           load_rejected,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic                           busy,
	output logic [eucjp_pkg::OUT_BITS-1:0] score,
	output logic                           rejected
);

	logic                           valid_q;
	logic [eucjp_pkg::OUT_BITS-1:0] score_q;
	logic                           rejected_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | (valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			score_q    <= load_score;
			rejected_q <= load_rejected;
		end
	end

	// Busy while a result is held and not taken in this cycle.
	assign busy      = valid_q & out_stall;
	assign out_valid = valid_q;
	assign score     = score_q;
	assign rejected  = rejected_q;

endmodule
